[rtl/rgb_diagonal_sharpen_blend_macros.svh]
// Assertion macros for the diagonal sharpen and blend block.
`ifndef RGB_DIAGONAL_SHARPEN_BLEND_MACROS_SVH
`define RGB_DIAGONAL_SHARPEN_BLEND_MACROS_SVH

`ifndef SYNTHESIS

`define RDSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rdsb assertion failed");

`define RDSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rdsb assertion failed");

`else

`define RDSB_ASSERT_NOW(lbl, clk, rst_n, ante, cons)

`define RDSB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/rdsb_pkg.sv]
// Constants, types and register codes of the diagonal sharpen and blend block.
package rdsb_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int RING_LEN  = 2 * MAX_WIDTH + 2;
	localparam int RING_AW   = $clog2(RING_LEN);
	localparam int COL_W     = $clog2(MAX_WIDTH);

	localparam int NCH   = 3;
	localparam int CH_W  = 8;
	localparam int PIX_W = NCH * CH_W;
	localparam int STR_W = 7;
	localparam int WID_W = 12;
	localparam int HGT_W = 16;
	localparam int ROW_W = HGT_W + 1;

	localparam int CFG_IW = 2;
	localparam int CFG_DW = 16;

	localparam int PCT       = 100;
	localparam int STR_RESET = 50;
	localparam int WID_RESET = 640;
	localparam int HGT_RESET = 480;
	localparam int MIN_DIM   = 3;

	// x * 256 / 100 is x * 64 / 25; the division by 25 is a reciprocal multiply.
	localparam int BLEND_SH = 8;
	localparam int PRE_SH   = 6;
	localparam int Q_DIV    = 25;
	localparam int RECIP_SH = 26;
	localparam int RECIP    = (2 ** RECIP_SH + Q_DIV - 1) / Q_DIV;
	localparam int PROD_W   = CH_W + STR_W;
	localparam int MUL_W    = 28;
	localparam int F_W      = 16;

	typedef logic [PIX_W-1:0]        pix_t;
	typedef logic [CH_W-1:0]         chan_t;
	typedef logic [CH_W+1:0]         tri_t;
	typedef logic [STR_W-1:0]        str_t;
	typedef logic [WID_W-1:0]        wid_t;
	typedef logic [WID_W:0]          wid_ext_t;
	typedef logic [HGT_W-1:0]        hgt_t;
	typedef logic [ROW_W-1:0]        row_t;
	typedef logic [COL_W-1:0]        col_t;
	typedef logic [RING_AW-1:0]      ring_addr_t;
	typedef logic [RING_AW:0]        ring_ext_t;
	typedef logic [PROD_W-1:0]       prod_t;
	typedef logic [MUL_W-1:0]        mulk_t;
	typedef logic [PROD_W+MUL_W-1:0] mul_t;
	typedef logic [F_W-1:0]          frac_t;
	typedef logic [F_W:0]            sum_t;
	typedef logic [CFG_IW-1:0]       cfg_idx_t;
	typedef logic [CFG_DW-1:0]       cfg_data_t;

	localparam mulk_t MUL_K = mulk_t'(RECIP * (2 ** PRE_SH));

	typedef enum logic [CFG_IW-1:0] {
		REG_STRENGTH = 2'd0,
		REG_WIDTH    = 2'd1,
		REG_HEIGHT   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic emit;
		logic interior;
		logic last;
	} flags_t;

endpackage

[rtl/rdsb_if.sv]
// Channel interfaces of the diagonal sharpen and blend block.
interface rdsb_pixel_if;
	logic                 valid;
	logic                 ready;
	rdsb_pkg::chan_t      red_in;
	rdsb_pkg::chan_t      green_in;
	rdsb_pkg::chan_t      blue_in;
	logic                 flush_item;

	modport source (output valid, red_in, green_in, blue_in, flush_item, input ready);
	modport sink (input valid, red_in, green_in, blue_in, flush_item, output ready);
endinterface

interface rdsb_result_if;
	logic                 valid;
	logic                 ready;
	logic                 out_valid;
	rdsb_pkg::chan_t      red_out;
	rdsb_pkg::chan_t      green_out;
	rdsb_pkg::chan_t      blue_out;
	logic                 image_last;

	modport source (output valid, out_valid, red_out, green_out, blue_out, image_last,
		input ready);
	modport sink (input valid, out_valid, red_out, green_out, blue_out, image_last,
		output ready);
endinterface

interface rdsb_cfg_if;
	logic                 valid;
	logic                 ready;
	rdsb_pkg::cfg_idx_t   index;
	rdsb_pkg::cfg_data_t  data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[rtl/rgb_diagonal_sharpen_blend.sv]
// Top level of the diagonal sharpen and blend block over a raster RGB stream.
// Pixels enter on the pixel channel in raster order, one item per pixel, and
// each accepted item yields exactly one item on the result channel. Results
// carry out_valid low while the first row plus one pixel fills the row store;
// after the image, flush items drain the remaining pixels, and image_last
// marks the final one, after which the next item starts a new image.
// The cfg channel writes strength, width and height; it is always ready and
// should only be written while no item is in flight.
// When the receiver does not stall, one item is taken per cycle: each item makes two
// reads of the single row store, and each pixel item inside the image one write.
// The result of an item is offered on the result channel through the read,
// product, reciprocal and output registers.
// Reset returns the registers to their defaults and the raster counters to
// zero; the row store is not cleared, as no unwritten entry reaches a result.
// When the receiver stalls, the result is held and the four stages keep
// filling; pixel ready falls only once every stage holds an item.
`include "rgb_diagonal_sharpen_blend_macros.svh"

module rgb_diagonal_sharpen_blend (
	input  logic            clk,
	input  logic            arst_n,
	rdsb_cfg_if.sink        cfg,
	rdsb_pixel_if.sink      pixel,
	rdsb_result_if.source   result
);

	rdsb_pkg::str_t       strength_q;
	rdsb_pkg::wid_t       width_q;
	rdsb_pkg::hgt_t       height_q;

	rdsb_pkg::wid_t       w_eff;
	rdsb_pkg::hgt_t       h_eff;
	rdsb_pkg::str_t       s_eff;

	rdsb_pkg::col_t       col_q;
	rdsb_pkg::row_t       row_q;
	rdsb_pkg::col_t       qc_q;
	rdsb_pkg::hgt_t       qr_q;
	rdsb_pkg::ring_addr_t wp_q;

	rdsb_pkg::pix_t       row_store [rdsb_pkg::RING_LEN];

	logic                 en1, en2, en3, en_o, acc;
	logic                 in_image, ignore0, col_wrap, qc_wrap;
	rdsb_pkg::flags_t     flags0;
	rdsb_pkg::pix_t       px0;
	rdsb_pkg::ring_ext_t  t_c, t_ul;
	rdsb_pkg::ring_addr_t addr_c, addr_ul;

	logic                 v_s1, v_s2, v_s3, ov_q;
	rdsb_pkg::flags_t     flags_s1, flags_s2, flags_s3;
	rdsb_pkg::pix_t       lr_s1, c_s1, ul_s1, c_s2, c_s3;

	rdsb_pkg::tri_t       tri_c   [rdsb_pkg::NCH];
	rdsb_pkg::tri_t       sub_ul  [rdsb_pkg::NCH];
	rdsb_pkg::tri_t       diff    [rdsb_pkg::NCH];
	rdsb_pkg::chan_t      d_ch    [rdsb_pkg::NCH];
	rdsb_pkg::prod_t      p1_s2   [rdsb_pkg::NCH];
	rdsb_pkg::prod_t      p2_s2   [rdsb_pkg::NCH];
	rdsb_pkg::mul_t       m1      [rdsb_pkg::NCH];
	rdsb_pkg::mul_t       m2      [rdsb_pkg::NCH];
	rdsb_pkg::frac_t      f1_s3   [rdsb_pkg::NCH];
	rdsb_pkg::frac_t      f2_s3   [rdsb_pkg::NCH];
	rdsb_pkg::sum_t       fsum    [rdsb_pkg::NCH];
	rdsb_pkg::pix_t       blended;
	rdsb_pkg::pix_t       res_pix;

	logic                 out_valid_q, image_last_q;
	rdsb_pkg::pix_t       out_pix_q;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= rdsb_pkg::str_t'(rdsb_pkg::STR_RESET);
			width_q    <= rdsb_pkg::wid_t'(rdsb_pkg::WID_RESET);
			height_q   <= rdsb_pkg::hgt_t'(rdsb_pkg::HGT_RESET);
		end else if (cfg.valid) begin
			unique case (rdsb_pkg::cfg_reg_t'(cfg.index))
				rdsb_pkg::REG_STRENGTH: strength_q <= cfg.data[rdsb_pkg::STR_W-1:0];
				rdsb_pkg::REG_WIDTH:    width_q    <= cfg.data[rdsb_pkg::WID_W-1:0];
				rdsb_pkg::REG_HEIGHT:   height_q   <= cfg.data[rdsb_pkg::HGT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(width_q) < rdsb_pkg::MIN_DIM) begin
			w_eff = rdsb_pkg::wid_t'(rdsb_pkg::MIN_DIM);
		end else if (int'(width_q) > rdsb_pkg::MAX_WIDTH) begin
			w_eff = rdsb_pkg::wid_t'(rdsb_pkg::MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		if (int'(height_q) < rdsb_pkg::MIN_DIM) begin
			h_eff = rdsb_pkg::hgt_t'(rdsb_pkg::MIN_DIM);
		end else begin
			h_eff = height_q;
		end
		if (int'(strength_q) > rdsb_pkg::PCT) begin
			s_eff = rdsb_pkg::str_t'(rdsb_pkg::PCT);
		end else begin
			s_eff = strength_q;
		end
	end

	// Handshake: each stage moves when the one after it is empty or moving.
	assign en_o        = !ov_q || result.ready;
	assign en3         = !v_s3 || en_o;
	assign en2         = !v_s2 || en3;
	assign en1         = !v_s1 || en2;
	assign pixel.ready = en1;
	assign acc         = pixel.valid && en1;

	// Raster position decode for the item at the input.
	assign px0      = {pixel.red_in, pixel.green_in, pixel.blue_in};
	assign in_image = row_q < rdsb_pkg::row_t'(h_eff);
	assign ignore0  = pixel.flush_item && in_image;
	assign col_wrap = (rdsb_pkg::wid_t'(col_q) + rdsb_pkg::wid_t'(1)) >= w_eff;
	assign qc_wrap  = (rdsb_pkg::wid_t'(qc_q) + rdsb_pkg::wid_t'(1)) >= w_eff;

	always_comb begin
		flags0.emit = !ignore0 && ((row_q >= rdsb_pkg::row_t'(2))
			|| ((row_q == rdsb_pkg::row_t'(1)) && (col_q != '0)));
		flags0.interior = in_image && (qr_q != '0) && (qc_q != '0)
			&& ((rdsb_pkg::row_t'(qr_q) + rdsb_pkg::row_t'(2)) <= rdsb_pkg::row_t'(h_eff))
			&& ((rdsb_pkg::wid_ext_t'(qc_q) + rdsb_pkg::wid_ext_t'(2))
				<= rdsb_pkg::wid_ext_t'(w_eff));
		flags0.last = flags0.emit && ((qr_q > (h_eff - rdsb_pkg::hgt_t'(1)))
			|| ((qr_q == (h_eff - rdsb_pkg::hgt_t'(1))) && qc_wrap));
	end

	// Read slots one row plus one pixel and two rows plus two pixels behind the write slot.
	always_comb begin
		t_c  = rdsb_pkg::ring_ext_t'(wp_q) + rdsb_pkg::ring_ext_t'(rdsb_pkg::RING_LEN)
			- rdsb_pkg::ring_ext_t'(w_eff) - rdsb_pkg::ring_ext_t'(1);
		t_ul = rdsb_pkg::ring_ext_t'(wp_q) + rdsb_pkg::ring_ext_t'(rdsb_pkg::RING_LEN)
			- rdsb_pkg::ring_ext_t'({w_eff, 1'b0}) - rdsb_pkg::ring_ext_t'(2);
		if (t_c >= rdsb_pkg::ring_ext_t'(rdsb_pkg::RING_LEN)) begin
			addr_c = rdsb_pkg::ring_addr_t'(t_c - rdsb_pkg::ring_ext_t'(rdsb_pkg::RING_LEN));
		end else begin
			addr_c = rdsb_pkg::ring_addr_t'(t_c);
		end
		if (t_ul >= rdsb_pkg::ring_ext_t'(rdsb_pkg::RING_LEN)) begin
			addr_ul = rdsb_pkg::ring_addr_t'(t_ul - rdsb_pkg::ring_ext_t'(rdsb_pkg::RING_LEN));
		end else begin
			addr_ul = rdsb_pkg::ring_addr_t'(t_ul);
		end
	end

	// Raster counters and ring write pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			qc_q  <= '0;
			qr_q  <= '0;
			wp_q  <= '0;
		end else if (acc && !ignore0) begin
			if (flags0.last) begin
				col_q <= '0;
				row_q <= '0;
				qc_q  <= '0;
				qr_q  <= '0;
				wp_q  <= '0;
			end else begin
				if (flags0.emit) begin
					if (qc_wrap) begin
						qc_q <= '0;
						qr_q <= qr_q + rdsb_pkg::hgt_t'(1);
					end else begin
						qc_q <= qc_q + rdsb_pkg::col_t'(1);
					end
				end
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_q + rdsb_pkg::row_t'(1);
				end else begin
					col_q <= col_q + rdsb_pkg::col_t'(1);
				end
				if (wp_q == rdsb_pkg::ring_addr_t'(rdsb_pkg::RING_LEN - 1)) begin
					wp_q <= '0;
				end else begin
					wp_q <= wp_q + rdsb_pkg::ring_addr_t'(1);
				end
			end
		end
	end

	// Row store: reads see the contents before this cycle's write.
	always_ff @(posedge clk) begin
		if (acc) begin
			c_s1  <= row_store[addr_c];
			ul_s1 <= row_store[addr_ul];
		end
		if (acc && !ignore0 && in_image) begin
			row_store[wp_q] <= px0;
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= pixel.valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en_o) begin
				ov_q <= v_s3;
			end
		end
	end

	// Sharpen and the two blend products.
	always_comb begin
		for (int k = 0; k < rdsb_pkg::NCH; k++) begin
			tri_c[k]  = rdsb_pkg::tri_t'({c_s1[k*rdsb_pkg::CH_W +: rdsb_pkg::CH_W], 1'b0})
				+ rdsb_pkg::tri_t'(c_s1[k*rdsb_pkg::CH_W +: rdsb_pkg::CH_W]);
			sub_ul[k] = rdsb_pkg::tri_t'(ul_s1[k*rdsb_pkg::CH_W +: rdsb_pkg::CH_W])
				+ rdsb_pkg::tri_t'(lr_s1[k*rdsb_pkg::CH_W +: rdsb_pkg::CH_W]);
			diff[k]   = tri_c[k] - sub_ul[k];
			if (tri_c[k] <= sub_ul[k]) begin
				d_ch[k] = '0;
			end else if (diff[k] > rdsb_pkg::tri_t'({rdsb_pkg::CH_W{1'b1}})) begin
				d_ch[k] = '1;
			end else begin
				d_ch[k] = diff[k][rdsb_pkg::CH_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			lr_s1    <= px0;
			flags_s1 <= flags0;
		end
		if (en2 && v_s1) begin
			c_s2     <= c_s1;
			flags_s2 <= flags_s1;
			for (int k = 0; k < rdsb_pkg::NCH; k++) begin
				p1_s2[k] <= rdsb_pkg::prod_t'(d_ch[k]) * rdsb_pkg::prod_t'(s_eff);
				p2_s2[k] <= rdsb_pkg::prod_t'(c_s1[k*rdsb_pkg::CH_W +: rdsb_pkg::CH_W])
					* rdsb_pkg::prod_t'(rdsb_pkg::str_t'(rdsb_pkg::PCT) - s_eff);
			end
		end
		if (en3 && v_s2) begin
			c_s3     <= c_s2;
			flags_s3 <= flags_s2;
			for (int k = 0; k < rdsb_pkg::NCH; k++) begin
				f1_s3[k] <= m1[k][rdsb_pkg::RECIP_SH +: rdsb_pkg::F_W];
				f2_s3[k] <= m2[k][rdsb_pkg::RECIP_SH +: rdsb_pkg::F_W];
			end
		end
	end

	// Division by 100 after the scale by 256, as a reciprocal multiply.
	always_comb begin
		for (int k = 0; k < rdsb_pkg::NCH; k++) begin
			m1[k] = rdsb_pkg::mul_t'(p1_s2[k]) * rdsb_pkg::mul_t'(rdsb_pkg::MUL_K);
			m2[k] = rdsb_pkg::mul_t'(p2_s2[k]) * rdsb_pkg::mul_t'(rdsb_pkg::MUL_K);
		end
	end

	always_comb begin
		for (int k = 0; k < rdsb_pkg::NCH; k++) begin
			fsum[k] = rdsb_pkg::sum_t'(f1_s3[k]) + rdsb_pkg::sum_t'(f2_s3[k]);
			blended[k*rdsb_pkg::CH_W +: rdsb_pkg::CH_W] =
				fsum[k][rdsb_pkg::BLEND_SH +: rdsb_pkg::CH_W];
		end
		if (!flags_s3.emit) begin
			res_pix = '0;
		end else if (flags_s3.interior) begin
			res_pix = blended;
		end else begin
			res_pix = c_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_o && v_s3) begin
			out_valid_q  <= flags_s3.emit;
			image_last_q <= flags_s3.last;
			out_pix_q    <= res_pix;
		end
	end

	assign result.valid      = ov_q;
	assign result.out_valid  = out_valid_q;
	assign result.image_last = image_last_q;
	assign result.red_out    = out_pix_q[2*rdsb_pkg::CH_W +: rdsb_pkg::CH_W];
	assign result.green_out  = out_pix_q[rdsb_pkg::CH_W +: rdsb_pkg::CH_W];
	assign result.blue_out   = out_pix_q[0 +: rdsb_pkg::CH_W];

	`RDSB_ASSERT_NOW(a_wp_range, clk, arst_n, 1'b1, wp_q < rdsb_pkg::ring_addr_t'(rdsb_pkg::RING_LEN))
	`RDSB_ASSERT_NEXT(a_end_clears, clk, arst_n, acc && flags0.last, (col_q == '0) && (row_q == '0) && (wp_q == '0))
	`RDSB_ASSERT_NEXT(a_flush_holds, clk, arst_n, acc && ignore0, $stable(col_q) && $stable(row_q) && $stable(wp_q))
	`RDSB_ASSERT_NOW(a_last_valid, clk, arst_n, result.valid && result.image_last, result.out_valid)

endmodule
